// ----- hdl/vtc_pkg.sv -----
`timescale 1ns / 1ps

package vtc_pkg;

	localparam int unsigned LENGTH_LIMIT_DEFAULT = 32'd65535;

	localparam int KIND_W   = 5;
	localparam int LENGTH_W = 16;
	localparam int FAULT_W  = 2;

	localparam logic [KIND_W-1:0] KIND_END     = 5'd0;
	localparam logic [KIND_W-1:0] KIND_IDENT   = 5'd1;
	localparam logic [KIND_W-1:0] KIND_KW_BASE = 5'd2;
	localparam logic [KIND_W-1:0] KIND_TIME    = 5'd15;
	localparam logic [KIND_W-1:0] KIND_SCALAR  = 5'd16;
	localparam logic [KIND_W-1:0] KIND_VECTOR  = 5'd17;

	localparam logic [FAULT_W-1:0] FAULT_NONE     = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_BAD_CHAR = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_NO_IDENT = 2'd2;
	localparam logic [FAULT_W-1:0] FAULT_DATA     = 2'd3;

	localparam logic [1:0] MODE_HEADER   = 2'd0;
	localparam logic [1:0] MODE_DUMPS    = 2'd1;
	localparam logic [1:0] MODE_AWAIT_ID = 2'd2;

	// Keyword table: index order gives the token kind offset.
	localparam int NKW    = 13;
	localparam int KW_MAX = 15;

	localparam int KW_END     = 1;
	localparam int KW_COMMENT = 4;
	localparam int KW_ENDDEFS = 8;

	localparam logic [3:0] KW_LEN [NKW] = '{
		4'd5, 4'd4, 4'd8, 4'd10, 4'd8, 4'd6, 4'd8, 4'd4, 4'd15, 4'd9, 4'd8, 4'd7, 4'd8
	};

	localparam logic [8*KW_MAX-1:0] KW_TEXT [NKW] = '{
		"$date", "$end", "$version", "$timescale", "$comment", "$scope",
		"$upscope", "$var", "$enddefinitions", "$dumpvars", "$dumpall",
		"$dumpon", "$dumpoff"
	};

	// Tail flag bit positions.
	localparam int TF_DIG  = 0;
	localparam int TF_SCL  = 1;
	localparam int TF_REAL = 2;
	localparam int TF_DOT  = 3;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [LENGTH_W-1:0] length;
		logic [FAULT_W-1:0]  fault;
		logic                last;
	} result_t;

	// Character at position pos of keyword idx; zero past the end of the text.
	function automatic logic [7:0] kw_char(input int idx, input logic [3:0] pos);
		logic [8*KW_MAX-1:0] word;
		word = KW_TEXT[idx] << (8 * (KW_MAX - int'(KW_LEN[idx])));
		if (pos == 4'd15) begin
			return 8'd0;
		end
		return word[8*(KW_MAX-1-int'(pos)) +: 8];
	endfunction

	function automatic logic is_scalar_mark(input logic [7:0] c);
		return (c == "0") || (c == "1") || (c == "x") || (c == "X") ||
			(c == "z") || (c == "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

endpackage

// ----- hdl/vtc_result_queue.sv -----
`timescale 1ns / 1ps

module vtc_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_count,
	input  vtc_pkg::result_t push_first,
	input  vtc_pkg::result_t push_second,
	input  logic             pop,
	output logic             room_for_two,
	output logic             head_valid,
	output vtc_pkg::result_t head
);
	import vtc_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	result_t            entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [PTR_W-1:0]   wr_next;
	logic               do_pop;

	assign wr_next      = wr_ptr_q + PTR_W'(1);
	assign head_valid   = (count_q != '0);
	assign head         = entry_q[rd_ptr_q];
	assign do_pop       = pop && head_valid;
	assign room_for_two = (count_q <= CNT_W'(QUEUE_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			entry_q[wr_ptr_q] <= push_first;
		end
		if (push_count == 2'd2) begin
			entry_q[wr_next] <= push_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_count);
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push_count) - CNT_W'(do_pop);
		end
	end

endmodule

// ----- hdl/vcd_token_classifier.sv -----
`timescale 1ns / 1ps
// Latency: the results of a byte are queued at its transfer and offered on the token side in order.
// Throughput: one byte per cycle; a byte may cause up to two results, queued four deep.
// text_ready drops while the result queue holds more than two results.
// Reset (arst_n low): section mode back to header, no token or comment pending,
// fault halt cleared, result queue emptied.
module vcd_token_classifier #(
	parameter int unsigned LENGTH_LIMIT = vtc_pkg::LENGTH_LIMIT_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          text_valid,
	output logic                          text_ready,
	input  logic [7:0]                    text_byte,
	input  logic                          stream_end,
	output logic                          token_valid,
	input  logic                          token_ready,
	output logic [vtc_pkg::KIND_W-1:0]    token_kind,
	output logic [vtc_pkg::LENGTH_W-1:0]  token_length,
	output logic [vtc_pkg::FAULT_W-1:0]   fault,
	output logic                          last_of_run
);
	import vtc_pkg::*;

	localparam logic [LENGTH_W-1:0] LEN_CAP =
		(LENGTH_LIMIT > 32'd65535) ? 16'hFFFF : LENGTH_W'(LENGTH_LIMIT);

	logic [1:0]          mode_q;
	logic                comment_q;
	logic                in_token_q;
	logic [LENGTH_W-1:0] count_q;
	logic [7:0]          lead_q;
	logic [NKW-1:0]      hits_q;
	logic [3:0]          tail_q;
	logic                halted_q;

	logic                accept;
	logic                live;
	logic                is_ws;
	logic                is_print;
	logic                is_bad;
	logic                flush;
	logic                extra;

	logic [KIND_W-1:0]   fin_kind;
	logic [FAULT_W-1:0]  fin_fault;
	logic                fin_halt;
	logic [1:0]          fin_mode;
	logic                fin_comment;
	logic                kw_found;
	logic [3:0]          kw_idx;

	logic [LENGTH_W-1:0] pos;
	logic [NKW-1:0]      hits_new;
	logic [3:0]          tail_new;
	logic [LENGTH_W-1:0] count_new;

	result_t             fin_res;
	result_t             extra_res;
	result_t             push_first;
	result_t             push_second;
	logic [1:0]          push_count;
	result_t             head;

	assign accept   = text_valid && text_ready;
	assign live     = !halted_q;
	assign is_ws    = !stream_end && ((text_byte == " ") || (text_byte == 8'h09) ||
		(text_byte == 8'h0A) || (text_byte == 8'h0D));
	assign is_print = !stream_end && (text_byte >= "!") && (text_byte <= "~");
	assign is_bad   = !stream_end && !is_ws && !is_print;
	assign flush    = in_token_q && (stream_end || is_ws || is_bad);

	// Classification of the pending token when it ends.
	always_comb begin
		fin_kind    = KIND_IDENT;
		fin_fault   = FAULT_NONE;
		fin_halt    = 1'b0;
		fin_mode    = mode_q;
		fin_comment = comment_q;
		kw_found    = 1'b0;
		kw_idx      = '0;
		// Descending so that the lowest matching index wins.
		for (int i = NKW - 1; i >= 0; i--) begin
			if (hits_q[i] && (count_q == LENGTH_W'(KW_LEN[i]))) begin
				kw_found = 1'b1;
				kw_idx   = 4'(i);
			end
		end
		if (kw_found) begin
			fin_kind = KIND_KW_BASE + KIND_W'(kw_idx);
			if (kw_idx == 4'(KW_END)) begin
				fin_comment = 1'b0;
			end
			if (kw_idx == 4'(KW_COMMENT)) begin
				fin_comment = 1'b1;
			end
			if (kw_idx == 4'(KW_ENDDEFS)) begin
				fin_mode = MODE_DUMPS;
			end
		end else if ((lead_q == "#") && (count_q > LENGTH_W'(1)) && tail_q[TF_DIG]) begin
			if (mode_q == MODE_AWAIT_ID) begin
				fin_kind  = KIND_END;
				fin_fault = FAULT_NO_IDENT;
				fin_halt  = 1'b1;
			end else if (mode_q == MODE_DUMPS) begin
				fin_kind = KIND_TIME;
			end
		end else if (mode_q == MODE_DUMPS) begin
			if (is_scalar_mark(lead_q)) begin
				fin_kind = KIND_SCALAR;
			end else if ((((lead_q == "b") || (lead_q == "B")) && tail_q[TF_SCL]) ||
					(((lead_q == "r") || (lead_q == "R")) && tail_q[TF_REAL])) begin
				fin_kind = KIND_VECTOR;
				fin_mode = MODE_AWAIT_ID;
			end else if (!comment_q) begin
				fin_kind  = KIND_END;
				fin_fault = FAULT_DATA;
				fin_halt  = 1'b1;
			end
		end else if (mode_q == MODE_AWAIT_ID) begin
			fin_mode = MODE_DUMPS;
		end
	end

	// Per-character update of the keyword and tail trackers.
	always_comb begin
		pos      = in_token_q ? count_q : '0;
		hits_new = in_token_q ? hits_q : '1;
		tail_new = in_token_q ? tail_q : 4'(1 << TF_DIG | 1 << TF_SCL | 1 << TF_REAL);
		if (in_token_q) begin
			if (!is_digit(text_byte)) begin
				tail_new[TF_DIG] = 1'b0;
			end
			if (!is_scalar_mark(text_byte)) begin
				tail_new[TF_SCL] = 1'b0;
			end
			if (text_byte == ".") begin
				if (tail_q[TF_DOT]) begin
					tail_new[TF_REAL] = 1'b0;
				end
				tail_new[TF_DOT] = 1'b1;
			end else if (!is_digit(text_byte)) begin
				tail_new[TF_REAL] = 1'b0;
			end
		end
		for (int i = 0; i < NKW; i++) begin
			if ((pos >= LENGTH_W'(KW_LEN[i])) || (kw_char(i, pos[3:0]) != text_byte)) begin
				hits_new[i] = 1'b0;
			end
		end
		if (!in_token_q) begin
			count_new = LENGTH_W'(1);
		end else if (count_q < LEN_CAP) begin
			count_new = count_q + LENGTH_W'(1);
		end else begin
			count_new = count_q;
		end
	end

	// A stream end or a bad character adds a result unless the flushed token faulted.
	assign extra = !(flush && fin_halt) && (stream_end || is_bad);

	always_comb begin
		fin_res.kind     = fin_kind;
		fin_res.length   = count_q;
		fin_res.fault    = fin_fault;
		fin_res.last     = !extra;
		extra_res.kind   = KIND_END;
		extra_res.length = '0;
		extra_res.fault  = stream_end ? FAULT_NONE : FAULT_BAD_CHAR;
		extra_res.last   = 1'b1;
		push_first       = flush ? fin_res : extra_res;
		push_second      = extra_res;
		if (accept && live) begin
			push_count = 2'(flush) + 2'(extra);
		end else begin
			push_count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_HEADER;
			comment_q  <= 1'b0;
			in_token_q <= 1'b0;
			count_q    <= '0;
			lead_q     <= '0;
			hits_q     <= '0;
			tail_q     <= '0;
			halted_q   <= 1'b0;
		end else if (accept && live) begin
			if (flush) begin
				in_token_q <= 1'b0;
				count_q    <= '0;
				mode_q     <= fin_mode;
				comment_q  <= fin_comment;
			end
			halted_q <= (flush && fin_halt) || is_bad;
			if (is_print) begin
				if (!in_token_q) begin
					lead_q <= text_byte;
				end
				in_token_q <= 1'b1;
				count_q    <= count_new;
				hits_q     <= hits_new;
				tail_q     <= tail_new;
			end
		end
	end

	vtc_result_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_count   (push_count),
		.push_first   (push_first),
		.push_second  (push_second),
		.pop          (token_ready),
		.room_for_two (text_ready),
		.head_valid   (token_valid),
		.head         (head)
	);

	assign token_kind   = head.kind;
	assign token_length = head.length;
	assign fault        = head.fault;
	assign last_of_run  = head.last;

endmodule

// ----- hdl/vtc_checker.sv -----
`timescale 1ns / 1ps

module vtc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          text_valid,
	input logic                          text_ready,
	input logic [7:0]                    text_byte,
	input logic                          stream_end,
	input logic                          token_valid,
	input logic                          token_ready,
	input logic [vtc_pkg::KIND_W-1:0]    token_kind,
	input logic [vtc_pkg::LENGTH_W-1:0]  token_length,
	input logic [vtc_pkg::FAULT_W-1:0]   fault,
	input logic                          last_of_run
);
	import vtc_pkg::*;

	// A waiting byte holds its payload until its transfer.
	assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_ready |=> text_valid && $stable(text_byte) && $stable(stream_end))
		else $error("waiting byte changed");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(token_kind) &&
		$stable(token_length) && $stable(fault) && $stable(last_of_run))
		else $error("stalled result changed");

	// A fault result carries the end kind and ends the run of its byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (fault != FAULT_NONE) |-> (token_kind == KIND_END) && last_of_run)
		else $error("fault result malformed");

	// Nothing follows the transfer of a fault result until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_ready && (fault != FAULT_NONE) |=> !token_valid)
		else $error("result after fault");

	// End and bad-character results have zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_kind == KIND_END) &&
		((fault == FAULT_NONE) || (fault == FAULT_BAD_CHAR)) |-> (token_length == '0))
		else $error("end result with length");

endmodule

bind vcd_token_classifier vtc_checker u_vtc_checker (.*);

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import vtc_pkg::*;

	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam int unsigned LEN_CAP =
		(LENGTH_LIMIT_DEFAULT > 65535) ? 65535 : LENGTH_LIMIT_DEFAULT;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic [7:0] text_byte = 8'h00;
	logic stream_end = 1'b0;
	logic token_ready = 1'b0;
	logic text_ready;
	logic token_valid;
	logic [KIND_W-1:0] token_kind;
	logic [LENGTH_W-1:0] token_length;
	logic [FAULT_W-1:0] fault;
	logic last_of_run;

	vcd_token_classifier uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_ready(text_ready),
		.text_byte(text_byte),
		.stream_end(stream_end),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.token_length(token_length),
		.fault(fault),
		.last_of_run(last_of_run)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Keywords in kind order: entry i is reported as KIND_KW_BASE + i.
	string kw_word [13] = '{
		"$date", "$end", "$version", "$timescale", "$comment", "$scope",
		"$upscope", "$var", "$enddefinitions", "$dumpvars", "$dumpall",
		"$dumpon", "$dumpoff"
	};

	// Tokenizer state as the block should hold it.
	logic [1:0] sect_mode = MODE_HEADER;
	logic in_note = 1'b0;
	logic mid_token = 1'b0;
	int unsigned token_chars = 0;
	logic [7:0] first_char = 8'h00;
	logic [12:0] kw_alive = '0;
	logic [3:0] tail_bits = '0;
	logic stopped = 1'b0;

	result_t expected_tokens [$];
	int mismatches = 0;
	int bytes_sent = 0;
	int results_checked = 0;
	logic [17:0] kinds_seen = '0;
	int fault_pick = 0;

	int burst_left = 0;
	logic sender_gaps = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	logic [15:0] ready_pattern = 16'hFFFF;
	int pattern_age = 0;

	function automatic logic digit_char(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic value_mark(input logic [7:0] c);
		return c == "0" || c == "1" || c == "x" || c == "X" || c == "z" || c == "Z";
	endfunction

	function automatic logic white_space(input logic [7:0] c);
		return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic void add_char(input logic [7:0] c);
		int unsigned pos;
		pos = mid_token ? token_chars : 0;
		if (!mid_token) begin
			mid_token = 1'b1;
			token_chars = 0;
			first_char = c;
			kw_alive = '1;
			tail_bits = '0;
			tail_bits[TF_DIG] = 1'b1;
			tail_bits[TF_SCL] = 1'b1;
			tail_bits[TF_REAL] = 1'b1;
		end else begin
			if (!digit_char(c))
				tail_bits[TF_DIG] = 1'b0;
			if (!value_mark(c))
				tail_bits[TF_SCL] = 1'b0;
			// A real value allows a single dot among its digits.
			if (c == ".") begin
				if (tail_bits[TF_DOT])
					tail_bits[TF_REAL] = 1'b0;
				tail_bits[TF_DOT] = 1'b1;
			end else if (!digit_char(c)) begin
				tail_bits[TF_REAL] = 1'b0;
			end
		end
		for (int i = 0; i < 13; i++) begin
			if (pos >= kw_word[i].len() || kw_word[i][pos] != c)
				kw_alive[i] = 1'b0;
		end
		if (token_chars < LEN_CAP)
			token_chars++;
	endfunction

	function automatic void close_token(output result_t r);
		int unsigned len;
		len = token_chars;
		mid_token = 1'b0;
		token_chars = 0;
		r.kind = KIND_IDENT;
		r.length = len[15:0];
		r.fault = FAULT_NONE;
		r.last = 1'b0;
		for (int i = 0; i < 13; i++) begin
			if (kw_alive[i] && len == kw_word[i].len()) begin
				if (i == KW_END)
					in_note = 1'b0;
				if (i == KW_COMMENT)
					in_note = 1'b1;
				if (i == KW_ENDDEFS)
					sect_mode = MODE_DUMPS;
				r.kind = KIND_KW_BASE + 5'(i);
				return;
			end
		end
		if (first_char == "#" && len > 1 && tail_bits[TF_DIG]) begin
			if (sect_mode == MODE_AWAIT_ID) begin
				stopped = 1'b1;
				r.kind = KIND_END;
				r.fault = FAULT_NO_IDENT;
			end else if (sect_mode == MODE_DUMPS) begin
				r.kind = KIND_TIME;
			end
			return;
		end
		if (sect_mode == MODE_DUMPS) begin
			if (value_mark(first_char)) begin
				r.kind = KIND_SCALAR;
			end else if (((first_char == "b" || first_char == "B") && tail_bits[TF_SCL]) ||
					((first_char == "r" || first_char == "R") && tail_bits[TF_REAL])) begin
				sect_mode = MODE_AWAIT_ID;
				r.kind = KIND_VECTOR;
			end else if (!in_note) begin
				stopped = 1'b1;
				r.kind = KIND_END;
				r.fault = FAULT_DATA;
			end
		end else if (sect_mode == MODE_AWAIT_ID) begin
			sect_mode = MODE_DUMPS;
		end
	endfunction

	// Works out the results that one accepted byte causes and queues them.
	function automatic void predict_byte(input logic [7:0] c, input logic e);
		result_t produced [2];
		result_t r;
		int n;
		n = 0;
		if (stopped)
			return;
		if (e || white_space(c) || c < 8'h21 || c > 8'h7E) begin
			if (mid_token) begin
				close_token(r);
				produced[n] = r;
				n++;
			end
			if (!stopped && (e || !white_space(c))) begin
				r.kind = KIND_END;
				r.length = '0;
				r.fault = e ? FAULT_NONE : FAULT_BAD_CHAR;
				r.last = 1'b0;
				produced[n] = r;
				n++;
				if (!e)
					stopped = 1'b1;
			end
		end else begin
			add_char(c);
		end
		if (n > 0)
			produced[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_tokens.push_back(produced[i]);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (token_valid && token_ready) begin
			if (expected_tokens.size() == 0) begin
				$display("%0t: unexpected result kind %0d length %0d fault %0d", $time,
					token_kind, token_length, fault);
				mismatches++;
			end else begin
				want = expected_tokens.pop_front();
				compare_field("token_kind", 32'(want.kind), 32'(token_kind));
				compare_field("token_length", 32'(want.length), 32'(token_length));
				compare_field("fault", 32'(want.fault), 32'(fault));
				compare_field("last_of_run", 32'(want.last), 32'(last_of_run));
				results_checked++;
				kinds_seen[want.kind] = 1'b1;
			end
		end
	end

	// Result side: a rotating stall pattern, now and then replaced, plus long
	// hold-offs on request.
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (pattern_age == 0) begin
			pattern_age = $urandom_range(30, 150);
			ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
		end
		pattern_age--;
		ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
		if (hold_left != 0) begin
			hold_left--;
			token_ready <= 1'b0;
		end else begin
			token_ready <= ready_pattern[0];
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic e);
		if (sender_gaps && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				text_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		text_valid <= 1'b1;
		text_byte <= b;
		stream_end <= e;
		@(posedge clk);
		while (!text_ready)
			@(posedge clk);
		bytes_sent++;
		predict_byte(b, e);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	task automatic send_from(input string set, input int n);
		repeat (n)
			send_byte(set[$urandom_range(0, set.len() - 1)], 1'b0);
	endtask

	task automatic send_printable(input int n);
		repeat (n)
			send_byte(8'($urandom_range(33, 126)), 1'b0);
	endtask

	task automatic send_end();
		send_byte(8'($urandom), 1'b1);
	endtask

	// A word that classifies as an identifier or scalar, never as a time,
	// keyword or vector, so it is safe after a vector and inside comments.
	task automatic send_word(input int max_len);
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (c == "#" || c == "$" || c == "b" || c == "B" || c == "r" || c == "R");
		send_byte(c, 1'b0);
		send_printable($urandom_range(0, max_len - 1));
	endtask

	task automatic send_sep();
		if ($urandom_range(0, 19) == 0)
			send_end();
		else
			send_from(" \t\n\015", $urandom_range(1, 3));
	endtask

	task automatic wait_for_results();
		text_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_tokens.size() != 0);
	endtask

	task automatic test_header_keywords();
		send_text("$date $version\t$timescale");
		send_byte(CH_LF, 1'b0);
		send_text("$scope");
		send_byte(CH_CR, 1'b0);
		send_text("$upscope $var $dumpvars $dumpall $dumpon $dumpoff $comment $end ");
		send_text("$en $ends $dat #12 # #1a ! ~   q");
		// Pending token flushed by the stream end, then an empty stream end.
		send_end();
		send_end();
		send_text("later ");
		wait_for_results();
	endtask

	// A long token whose length runs well past eight bits.
	task automatic test_long_token();
		sender_gaps = 1'b0;
		repeat (300)
			send_byte("a", 1'b0);
		send_byte(CH_SP, 1'b0);
		sender_gaps = 1'b1;
		wait_for_results();
	endtask

	task automatic test_dump_values();
		send_text("$enddefinitions\n#0 #123 0! 1a x# Z% X z\t");
		send_text("b1010 ! B01xXzZ 7 b x r1.5 id R12 q r.5 w r y");
		send_byte(CH_CR, 1'b0);
		send_text("b1 $dumpon k $comment hello r1.2.3 b2 #a #5 $end ");
		send_byte("b", 1'b0);
		send_from("01xXzZ", 20);
		send_text(" !! b0");
		// A stream end between a vector and its identifier keeps the mode.
		send_end();
		send_text("v 1");
		send_end();
		wait_for_results();
	endtask

	task automatic test_random_dumps(input int count);
		int stop_at;
		int idx;
		stop_at = bytes_sent + count;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4: begin
					send_byte("#", 1'b0);
					send_from("0123456789", $urandom_range(1, 8));
				end
				5, 6, 7, 8, 9: begin
					send_from("01xXzZ", 1);
					send_printable($urandom_range(0, 6));
				end
				10, 11, 12: begin
					send_from("bB", 1);
					send_from("01xXzZ", $urandom_range(0, 16));
					send_sep();
					send_word(8);
				end
				13, 14: begin
					send_from("rR", 1);
					send_from("0123456789", $urandom_range(0, 4));
					if ($urandom_range(0, 1) == 1) begin
						send_byte(".", 1'b0);
						send_from("0123456789", $urandom_range(0, 4));
					end
					send_sep();
					send_word(8);
				end
				15, 16: begin
					idx = $urandom_range(0, 12);
					if (idx == KW_COMMENT || $urandom_range(0, 1) == 1) begin
						send_text("$comment");
						repeat ($urandom_range(1, 6)) begin
							send_sep();
							send_word(10);
						end
						send_sep();
						send_text("$end");
					end else begin
						send_text(kw_word[idx]);
					end
				end
				17: begin
					// A keyword between a vector and its identifier leaves the mode alone.
					send_text("b1");
					send_sep();
					send_text("$dumpall");
					send_sep();
					send_word(8);
				end
				18: send_from(" \t\n\015", $urandom_range(5, 20));
				default: begin
					send_from("01xXzZ", 1);
					send_printable($urandom_range(30, 300));
				end
			endcase
			send_sep();
		end
		wait_for_results();
	endtask

	task automatic test_result_stall();
		hold_request = 300;
		sender_gaps = 1'b0;
		repeat (40) begin
			send_byte("#", 1'b0);
			send_from("0123456789", 2);
			send_byte(CH_SP, 1'b0);
		end
		sender_gaps = 1'b1;
		wait_for_results();
	endtask

	task automatic test_fault_and_halt();
		logic [7:0] bad;
		fault_pick = $urandom_range(1, 3);
		if (fault_pick == FAULT_BAD_CHAR) begin
			do
				bad = 8'($urandom);
			while ((bad >= 8'h21 && bad <= 8'h7E) || white_space(bad));
			if ($urandom_range(0, 1) == 1)
				send_text("1q");
			send_byte(bad, 1'b0);
		end else if (fault_pick == FAULT_NO_IDENT) begin
			send_text("b01 #42 ");
		end else begin
			send_text("hello ");
		end
		// Once halted, nothing gets through: not text, not a stream end.
		for (int i = 0; i < 256; i++)
			send_byte(8'(i), (i % 5) == 4);
		send_text("#1 b1 x $end ");
		send_end();
		wait_for_results();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_keywords();
		test_long_token();
		test_dump_values();
		test_random_dumps(600);
		test_result_stall();
		test_fault_and_halt();
		repeat (20) @(posedge clk);
		$display("Sent %0d bytes and checked %0d results, %0d of 18 token kinds seen.",
			bytes_sent, results_checked, $countones(kinds_seen));
		$display("Closed on fault code %0d, then confirmed the block stays halted.",
			fault_pick);
		if (mismatches == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/vtc_pkg.sv
hdl/vtc_result_queue.sv
hdl/vcd_token_classifier.sv
hdl/vtc_checker.sv
verif/tb_top.sv
